// ===== rtl/vdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the voxel density dissolve block.
package vdd_pkg;

   localparam int FIELD_W    = 24;
   localparam int SPEED_W    = 17;
   localparam int NUM_COLORS = 3;
   localparam int INDEX_W    = 2;

   localparam logic [SPEED_W-1:0] INV_SPEED_RESET = 17'd65536;

   typedef enum logic [INDEX_W-1:0] {
      REG_INV_SPEED    = 2'd0,
      REG_LOG_MODE     = 2'd1,
      REG_HEAT_ENABLE  = 2'd2,
      REG_COLOR_ENABLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SPEED_W-1:0] inv_speed;
      logic               log_mode;
      logic               heat_enable;
      logic               color_enable;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_W-1:0]        density_in;
      logic signed [FIELD_W-1:0] heat_in;
      logic [FIELD_W-1:0]        red_in;
      logic [FIELD_W-1:0]        green_in;
      logic [FIELD_W-1:0]        blue_in;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0]        density_out;
      logic signed [FIELD_W-1:0] heat_out;
      logic [FIELD_W-1:0]        red_out;
      logic [FIELD_W-1:0]        green_out;
      logic [FIELD_W-1:0]        blue_out;
      logic                      last_out;
   } rsp_type;

   // Result of the first stage: new density and heat, colors still untouched.
   typedef struct packed {
      logic [FIELD_W-1:0]                  density;
      logic signed [FIELD_W-1:0]           heat;
      logic [NUM_COLORS-1:0][FIELD_W-1:0]  color;
      logic [FIELD_W-1:0]                  divisor;
      logic                                last;
      logic                                divide;
      logic                                scale_log;
   } front_type;

   // One color lane of the divider: partial remainder and the word that
   // shifts dividend bits out and quotient bits in.
   typedef struct packed {
      logic [FIELD_W-1:0] rem;
      logic [FIELD_W-1:0] acc;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_COLORS-1:0] lane;
      logic [FIELD_W-1:0]        divisor;
      logic                      divide;
      logic [FIELD_W-1:0]        density;
      logic signed [FIELD_W-1:0] heat;
      logic                      last;
   } cell_type;

endpackage

// ===== rtl/vdd_front.sv =====
`timescale 1ns / 1ps
// First stage: decay step, new density and new heat.
module vdd_front #(
   parameter int FRAC_BITS = 16,
   localparam int StepW = FRAC_BITS + 1,
   localparam int MulW  = (StepW > vdd_pkg::FIELD_W) ? StepW : vdd_pkg::FIELD_W
) (
   input  logic                clock,
   input  logic                reset,
   input  vdd_pkg::cfg_type    cfg,
   input  logic                up_valid,
   output logic                up_ready,
   input  vdd_pkg::req_type    up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output vdd_pkg::front_type  dn_data,
   output logic [MulW-1:0]     dn_factor
);
   import vdd_pkg::*;

   localparam int SatW  = (SPEED_W > StepW) ? SPEED_W : StepW;
   localparam int ProdW = FIELD_W + StepW;

   logic [SatW-1:0]    one_w;
   logic [SatW-1:0]    speed_w;
   logic [SatW-1:0]    step_w;
   logic [SatW-1:0]    fac_w;
   logic [StepW-1:0]   step;
   logic [StepW-1:0]   fac;
   logic [MulW-1:0]    step_l;
   logic [MulW-1:0]    dens_l;
   logic [MulW-1:0]    hmag_l;
   logic [MulW-1:0]    dens_diff;
   logic [MulW-1:0]    heat_diff;
   logic [ProdW-1:0]   dens_prod;
   logic [ProdW-1:0]   heat_prod;
   logic [FIELD_W-1:0] hraw;
   logic               hneg;
   logic [FIELD_W-1:0] hmag;
   logic [FIELD_W-1:0] new_dens;
   logic [FIELD_W-1:0] heat_mag;
   logic [FIELD_W-1:0] new_heat;

   front_type          data_ff, data_in;
   logic [MulW-1:0]    factor_ff, factor_in;
   logic               valid_ff, valid_in;

   always_comb begin
      one_w   = SatW'(1) << FRAC_BITS;
      speed_w = SatW'(cfg.inv_speed);
      step_w  = (speed_w > one_w) ? one_w : speed_w;
      fac_w   = one_w - step_w;
      step    = step_w[StepW-1:0];
      fac     = fac_w[StepW-1:0];
   end

   always_comb begin
      hraw   = up_data.heat_in;
      hneg   = hraw[FIELD_W-1];
      hmag   = hneg ? (~hraw + 1'b1) : hraw;
      step_l = MulW'(step);
      dens_l = MulW'(up_data.density_in);
      hmag_l = MulW'(hmag);

      dens_prod = ProdW'(up_data.density_in) * ProdW'(fac);
      heat_prod = ProdW'(hmag) * ProdW'(fac);
      dens_diff = (dens_l > step_l) ? (dens_l - step_l) : '0;
      heat_diff = (hmag_l < step_l) ? '0 : (hmag_l - step_l);

      if (cfg.log_mode) begin
         new_dens = dens_prod[FRAC_BITS +: FIELD_W];
         heat_mag = heat_prod[FRAC_BITS +: FIELD_W];
      end else begin
         new_dens = dens_diff[FIELD_W-1:0];
         heat_mag = heat_diff[FIELD_W-1:0];
      end
      new_heat = hneg ? (~heat_mag + 1'b1) : heat_mag;
   end

   always_comb begin
      data_in.density   = new_dens;
      data_in.heat      = cfg.heat_enable ? new_heat : hraw;
      data_in.color[0]  = up_data.red_in;
      data_in.color[1]  = up_data.green_in;
      data_in.color[2]  = up_data.blue_in;
      data_in.divisor   = up_data.density_in;
      data_in.last      = up_data.last_in;
      data_in.divide    = cfg.color_enable && !cfg.log_mode && (up_data.density_in != '0);
      data_in.scale_log = cfg.color_enable && cfg.log_mode;
      // Colors are later multiplied by the log factor or by the new density.
      factor_in         = cfg.log_mode ? MulW'(fac) : MulW'(new_dens);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff   <= data_in;
         factor_ff <= factor_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_data   = data_ff;
   assign dn_factor = factor_ff;

endmodule

// ===== rtl/vdd_scale.sv =====
`timescale 1ns / 1ps
// Second stage: color products and loading of the divider lanes.
module vdd_scale #(
   parameter int FRAC_BITS = 16,
   localparam int StepW = FRAC_BITS + 1,
   localparam int MulW  = (StepW > vdd_pkg::FIELD_W) ? StepW : vdd_pkg::FIELD_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  vdd_pkg::front_type  up_data,
   input  logic [MulW-1:0]     up_factor,
   output logic                dn_valid,
   input  logic                dn_ready,
   output vdd_pkg::cell_type   dn_data
);
   import vdd_pkg::*;

   localparam int ProdW = FIELD_W + MulW;

   cell_type data_ff, data_in;
   logic     valid_ff, valid_in;

   always_comb begin
      logic [ProdW-1:0] prod;
      data_in.divisor = up_data.divisor;
      data_in.divide  = up_data.divide;
      data_in.density = up_data.density;
      data_in.heat    = up_data.heat;
      data_in.last    = up_data.last;
      for (int k = 0; k < NUM_COLORS; k++) begin
         prod = ProdW'(up_data.color[k]) * ProdW'(up_factor);
         if (up_data.scale_log) begin
            data_in.lane[k].rem = '0;
            data_in.lane[k].acc = prod[FRAC_BITS +: FIELD_W];
         end else if (up_data.divide) begin
            // The quotient fits the field since the new density never
            // exceeds the old one, so the upper half is below the divisor.
            data_in.lane[k].rem = prod[2*FIELD_W-1:FIELD_W];
            data_in.lane[k].acc = prod[FIELD_W-1:0];
         end else begin
            data_in.lane[k].rem = '0;
            data_in.lane[k].acc = up_data.color[k];
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/vdd_cell.sv =====
`timescale 1ns / 1ps
// One divider cell: one quotient bit for each of the three color lanes.
module vdd_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  vdd_pkg::cell_type  up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output vdd_pkg::cell_type  dn_data
);
   import vdd_pkg::*;

   cell_type data_ff, data_in;
   logic     valid_ff, valid_in;

   always_comb begin
      logic [FIELD_W:0] trial;
      logic [FIELD_W:0] diff;
      logic             ge;
      data_in = up_data;
      for (int k = 0; k < NUM_COLORS; k++) begin
         trial = {up_data.lane[k].rem, up_data.lane[k].acc[FIELD_W-1]};
         diff  = trial - {1'b0, up_data.divisor};
         ge    = trial >= {1'b0, up_data.divisor};
         if (up_data.divide) begin
            data_in.lane[k].rem = ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
            data_in.lane[k].acc = {up_data.lane[k].acc[FIELD_W-2:0], ge};
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/voxel_density_dissolve.sv =====
`timescale 1ns / 1ps
// Top level of the voxel density dissolve block.
// Each voxel transaction goes through a step stage, a color product stage
// and a chain of 24 divider cells, one quotient bit per cell, which makes
// FIELD_W + 2 = 26 register stages, and a new transaction can be taken every
// cycle unless the response side holds back results. Every stage holds its
// own valid bit and moves forward whenever the stage after it is empty or
// moving, so bubbles close up while a result waits on the response side. The
// output register is the last divider cell. Configuration registers are read
// live and must only be written while the block holds no transaction.
module voxel_density_dissolve #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vdd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vdd_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [vdd_pkg::INDEX_W-1:0]   csr_index,
   input  logic [vdd_pkg::SPEED_W-1:0]   csr_wdata
);
   import vdd_pkg::*;

   localparam int StepW = FRAC_BITS + 1;
   localparam int MulW  = (StepW > FIELD_W) ? StepW : FIELD_W;

   cfg_type          cfg_ff;
   logic             front_valid, front_ready;
   front_type        front_data;
   logic [MulW-1:0]  front_factor;
   logic [FIELD_W:0] chain_valid;
   logic [FIELD_W:0] chain_ready;
   cell_type         chain_data [FIELD_W+1];
   cell_type         tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{inv_speed: INV_SPEED_RESET, log_mode: 1'b0,
                     heat_enable: 1'b1, color_enable: 1'b1};
      end else if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_INV_SPEED:    cfg_ff.inv_speed    <= csr_wdata;
            REG_LOG_MODE:     cfg_ff.log_mode     <= csr_wdata[0];
            REG_HEAT_ENABLE:  cfg_ff.heat_enable  <= csr_wdata[0];
            REG_COLOR_ENABLE: cfg_ff.color_enable <= csr_wdata[0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   vdd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .up_valid  (req_valid),
      .up_ready  (req_ready),
      .up_data   (req_data),
      .dn_valid  (front_valid),
      .dn_ready  (front_ready),
      .dn_data   (front_data),
      .dn_factor (front_factor)
   );

   vdd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (front_valid),
      .up_ready  (front_ready),
      .up_data   (front_data),
      .up_factor (front_factor),
      .dn_valid  (chain_valid[0]),
      .dn_ready  (chain_ready[0]),
      .dn_data   (chain_data[0])
   );

   for (genvar i = 0; i < FIELD_W; i++) begin : g_cell
      vdd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   assign chain_ready[FIELD_W] = rsp_ready;
   assign tail                 = chain_data[FIELD_W];
   assign rsp_valid            = chain_valid[FIELD_W];

   always_comb begin
      rsp_data.density_out = tail.density;
      rsp_data.heat_out    = tail.heat;
      rsp_data.red_out     = tail.lane[0].acc;
      rsp_data.green_out   = tail.lane[1].acc;
      rsp_data.blue_out    = tail.lane[2].acc;
      rsp_data.last_out    = tail.last;
   end

`ifndef SYNTHESIS
   // Input back-pressure only when every stage is full and the output stalls.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (front_valid && (&chain_valid) && !rsp_ready))
      else $error("request side stalled while the pipeline has a free stage");

   // A finished division leaves a remainder below the divisor in every lane.
   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && tail.divide) |->
         ((tail.lane[0].rem < tail.divisor) && (tail.lane[1].rem < tail.divisor)
          && (tail.lane[2].rem < tail.divisor)))
      else $error("divider remainder not below the divisor");

   // Reset empties the output stage.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

// ===== dv/vdd_voxel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the voxel density dissolve block: predicts each voxel and compares the results.
module vdd_voxel_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  vdd_pkg::req_type            req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  vdd_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_en,
   input  logic [vdd_pkg::INDEX_W-1:0] csr_index,
   input  logic [vdd_pkg::SPEED_W-1:0] csr_wdata,
   output int                          mismatch_count,
   output int                          pending_voxels,
   output int                          results_checked
);

   import vdd_pkg::*;

   cfg_type dissolve_cfg;
   rsp_type expected_voxels[$];

   initial begin
      mismatch_count  = 0;
      pending_voxels  = 0;
      results_checked = 0;
   end

   function automatic logic [63:0] fade(input logic [63:0] x, input logic [63:0] fac);
      return (x * fac) >> FRAC_BITS;
   endfunction

   function automatic rsp_type dissolve_voxel(input req_type v, input cfg_type c);
      logic [63:0]        one_q, step, fac, dens, hraw, hmag, m, signed_m, nd;
      logic [63:0]        col [NUM_COLORS];
      logic [FIELD_W-1:0] hout;
      logic               hneg;
      rsp_type            r;
      one_q  = 64'd1 << FRAC_BITS;
      step   = (c.inv_speed > one_q) ? one_q : 64'(c.inv_speed);
      dens   = 64'(v.density_in);
      hraw   = 64'(v.heat_in[FIELD_W-1:0]);
      hneg   = v.heat_in[FIELD_W-1];
      // Heat is handled as sign and magnitude, so truncation goes toward zero.
      hmag   = hneg ? (64'd1 << FIELD_W) - hraw : hraw;
      hout   = v.heat_in[FIELD_W-1:0];
      col[0] = 64'(v.red_in);
      col[1] = 64'(v.green_in);
      col[2] = 64'(v.blue_in);
      if (c.log_mode) begin
         fac = one_q - step;
         nd  = fade(dens, fac);
         if (c.heat_enable) begin
            m        = fade(hmag, fac);
            signed_m = hneg ? -m : m;
            hout     = signed_m[FIELD_W-1:0];
         end
         if (c.color_enable) begin
            for (int k = 0; k < NUM_COLORS; k++) col[k] = fade(col[k], fac);
         end
      end else begin
         nd = (dens > step) ? dens - step : 64'd0;
         if (c.heat_enable) begin
            m        = (hmag < step) ? 64'd0 : hmag - step;
            signed_m = hneg ? -m : m;
            hout     = signed_m[FIELD_W-1:0];
         end
         if (c.color_enable && dens != 64'd0) begin
            for (int k = 0; k < NUM_COLORS; k++) col[k] = (col[k] * nd) / dens;
         end
      end
      r.density_out = nd[FIELD_W-1:0];
      r.heat_out    = hout;
      r.red_out     = col[0][FIELD_W-1:0];
      r.green_out   = col[1][FIELD_W-1:0];
      r.blue_out    = col[2][FIELD_W-1:0];
      r.last_out    = v.last_in;
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         dissolve_cfg = '{inv_speed: INV_SPEED_RESET, log_mode: 1'b0,
                          heat_enable: 1'b1, color_enable: 1'b1};
         expected_voxels.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_INV_SPEED:    dissolve_cfg.inv_speed    = csr_wdata;
               REG_LOG_MODE:     dissolve_cfg.log_mode     = csr_wdata[0];
               REG_HEAT_ENABLE:  dissolve_cfg.heat_enable  = csr_wdata[0];
               REG_COLOR_ENABLE: dissolve_cfg.color_enable = csr_wdata[0];
            endcase
         end
         if (req_valid && req_ready) begin
            expected_voxels.push_back(dissolve_voxel(req_data, dissolve_cfg));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_voxels.size() == 0) begin
               $error("Result transaction arrived with no voxel outstanding");
               mismatch_count++;
            end else begin
               want = expected_voxels.pop_front();
               check_field("density_out", {8'd0, want.density_out}, {8'd0, rsp_data.density_out});
               check_field("heat_out", want.heat_out, rsp_data.heat_out);
               check_field("red_out", {8'd0, want.red_out}, {8'd0, rsp_data.red_out});
               check_field("green_out", {8'd0, want.green_out}, {8'd0, rsp_data.green_out});
               check_field("blue_out", {8'd0, want.blue_out}, {8'd0, rsp_data.blue_out});
               check_field("last_out", {31'd0, want.last_out}, {31'd0, rsp_data.last_out});
               results_checked++;
            end
         end
      end
      pending_voxels <= expected_voxels.size();
   end

endmodule

// ===== dv/tb_voxel_density_dissolve.sv =====
`timescale 1ns / 1ps
// Testbench top for the voxel density dissolve block: stimulus, idling and verdict.
module tb_voxel_density_dissolve;

   import vdd_pkg::*;

   localparam int FRAC_BITS      = 16;
   localparam int RESULT_LATENCY = 26;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 90;
   localparam int CYCLE_LIMIT    = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_write_en;
   logic [INDEX_W-1:0] csr_index;
   logic [SPEED_W-1:0] csr_wdata;

   int                 mismatch_count;
   int                 pending_voxels;
   int                 results_checked;
   int                 idle_pct = 0;
   int                 stall_left = 0;
   int                 cycles = 0;
   int                 voxels_sent = 0;
   int                 settings_used = 0;
   logic [SPEED_W-1:0] cur_speed = INV_SPEED_RESET;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   voxel_density_dissolve #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   vdd_voxel_checker #(.FRAC_BITS(FRAC_BITS)) voxel_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_voxels  (pending_voxels),
      .results_checked (results_checked)
   );

   // Response side backpressure comes in bursts whose odds are set per phase.
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out with %0d voxels outstanding", pending_voxels);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type voxel_of(input logic [FIELD_W-1:0] d, h, r, g, b,
                                        input logic l);
      req_type v;
      v.density_in = d;
      v.heat_in    = h;
      v.red_in     = r;
      v.green_in   = g;
      v.blue_in    = b;
      v.last_in    = l;
      return v;
   endfunction

   // Values cluster around zero, full scale and the current step, where the
   // clamping and truncation rules change.
   function automatic logic [FIELD_W-1:0] pick_level(input logic [63:0] step);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return FIELD_W'(step + $urandom_range(0, 2) - 1);
         3:       return FIELD_W'($urandom_range(0, 1 << 18));
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_heat(input logic [63:0] step);
      logic [FIELD_W-1:0] h;
      case ($urandom_range(0, 9))
         0:       h = 24'h800000;
         1:       h = 24'h7FFFFF;
         default: h = pick_level(step);
      endcase
      if (h != 24'h800000 && $urandom_range(0, 1) == 1) h = -h;
      return h;
   endfunction

   function automatic req_type random_voxel();
      logic [63:0] step;
      step = (cur_speed > 17'd65536) ? 64'd65536 : 64'(cur_speed);
      return voxel_of(pick_level(step), pick_heat(step), pick_level(step),
                      pick_level(step), pick_level(step), $urandom_range(0, 15) == 0);
   endfunction

   task automatic send_voxel(input req_type v);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      voxels_sent++;
   endtask

   // Stop sending and wait until every voxel in flight has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_voxels != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [SPEED_W-1:0] speed, input logic log_m,
                                input logic heat_en, input logic color_en);
      csr_write_en <= 1'b1;
      csr_index    <= REG_INV_SPEED;
      csr_wdata    <= speed;
      @(posedge clock);
      csr_index <= REG_LOG_MODE;
      csr_wdata <= SPEED_W'(log_m);
      @(posedge clock);
      csr_index <= REG_HEAT_ENABLE;
      csr_wdata <= SPEED_W'(heat_en);
      @(posedge clock);
      csr_index <= REG_COLOR_ENABLE;
      csr_wdata <= SPEED_W'(color_en);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_speed = speed;
      settings_used++;
   endtask

   initial begin
      logic [SPEED_W-1:0] speed;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      rsp_ready    <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index    <= REG_INV_SPEED;
      csr_wdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: linear falloff by a full unit, heat and colors on.
      settings_used = 1;
      send_voxel(voxel_of(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0));
      send_voxel(voxel_of(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
      send_voxel(voxel_of(24'h010000, 24'h800000, 24'hFFFFFF, 24'h123456, 24'h000001, 1'b0));
      send_voxel(voxel_of(24'h010001, 24'h010000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 1'b0));
      send_voxel(voxel_of(24'h000000, 24'hFF0000, 24'hABCDEF, 24'hFFFFFF, 24'h000001, 1'b1));
      send_voxel(voxel_of(24'h020000, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
      send_voxel(voxel_of(24'hFFFFFF, 24'hFF0001, 24'h000001, 24'h000002, 24'h000003, 1'b0));
      settle();

      // A zero step must leave everything unchanged in both modes.
      apply_setting(17'd0, 1'b1, 1'b1, 1'b1);
      send_voxel(voxel_of(24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
      send_voxel(voxel_of(24'h123456, 24'hFEDCBA, 24'h654321, 24'h000000, 24'h0F0F0F, 1'b0));
      settle();
      apply_setting(17'd0, 1'b0, 1'b1, 1'b1);
      send_voxel(voxel_of(24'hFFFFFF, 24'h800001, 24'hFFFFFF, 24'h000000, 24'h555555, 1'b0));
      send_voxel(voxel_of(24'h000001, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
      settle();

      // Step above one saturates, so the log factor is zero; heat is off.
      apply_setting(17'h1FFFF, 1'b1, 1'b0, 1'b1);
      send_voxel(voxel_of(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
      send_voxel(voxel_of(24'hFFFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h000001, 1'b0));
      settle();

      // Smallest step with colors off: colors pass, heat of magnitude one clears.
      apply_setting(17'd1, 1'b0, 1'b1, 1'b0);
      send_voxel(voxel_of(24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 1'b0));
      send_voxel(voxel_of(24'hFFFFFF, 24'h000001, 24'h000000, 24'hFFFFFF, 24'h123456, 1'b1));
      settle();

      apply_setting(17'd32768, 1'b1, 1'b1, 1'b1);
      send_voxel(voxel_of(24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 1'b1));
      send_voxel(voxel_of(24'hFFFFFF, 24'hFFFFFF, 24'h000003, 24'hFFFFFE, 24'h800001, 1'b0));
      settle();
      apply_setting(17'd65537, 1'b0, 1'b1, 1'b1);
      send_voxel(voxel_of(24'h010000, 24'hFEFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
      send_voxel(voxel_of(24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h00FFFF, 24'h000000, 1'b1));
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0:       speed = 17'd65536;
            1:       speed = 17'd1;
            2:       speed = 17'd0;
            3:       speed = SPEED_W'($urandom_range(65537, 131071));
            4:       speed = SPEED_W'($urandom_range(1, 255));
            default: speed = SPEED_W'($urandom_range(1, 65536));
         endcase
         apply_setting(speed, $urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) != 0);
         // Some phases run without idling, and the final one always does.
         if (phase == RANDOM_PHASES - 1 || phase % 4 == 1) idle_pct <= 0;
         else if (phase % 4 == 0) idle_pct <= 10;
         else if (phase % 4 == 2) idle_pct <= 25;
         else idle_pct <= 50;
         repeat (PHASE_ITEMS) send_voxel(random_voxel());
         settle();
      end

      repeat (RESULT_LATENCY + 8) @(posedge clock);
      $display("Sent %0d voxels under %0d register settings, covering linear and log falloff",
               voxels_sent, settings_used);
      $display("with heat and color handling on and off; %0d results compared.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
